### design/ssl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssl_pkg
// Shared constants, types and keyword lookup for the source lexer.
// ---------------------------------------------------------------------------
package ssl_pkg;

  localparam int OFFSET_BITS_DEF   = 32;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int LINE_BITS_DEF     = 24;
  localparam int KEYWORD_CHARS_DEF = 6;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_EQUAL   = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS    = 6'd17;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_NUMBER  = 6'd21;
  localparam logic [5:0] K_BIGINT  = 6'd22;
  localparam logic [5:0] K_ERROR   = 6'd41;
  localparam logic [5:0] K_EOF     = 6'd42;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNEXPECT = 2'd1;
  localparam logic [1:0] ERR_UNTERM   = 2'd2;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_OP2     = 3'd1;
  localparam logic [2:0] M_COMMENT = 3'd2;
  localparam logic [2:0] M_NUMBER  = 3'd3;
  localparam logic [2:0] M_NUMDOT  = 3'd4;
  localparam logic [2:0] M_IDENT   = 3'd5;
  localparam logic [2:0] M_STRING  = 3'd6;

  // classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       digit;
    logic       alnum;
  } cls_t;

  function automatic logic [5:0] op_base(input logic [7:0] c);
    case (c)
      8'h21:   op_base = K_BANG;
      8'h3D:   op_base = K_EQUAL;
      8'h3E:   op_base = K_GREATER;
      8'h3C:   op_base = K_LESS;
      default: op_base = K_SLASH;
    endcase
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      8'h28:   single_kind = K_LPAREN;
      8'h29:   single_kind = K_RPAREN;
      8'h7B:   single_kind = K_LBRACE;
      8'h7D:   single_kind = K_RBRACE;
      8'h2C:   single_kind = K_COMMA;
      8'h2E:   single_kind = K_DOT;
      8'h2D:   single_kind = K_MINUS;
      8'h2B:   single_kind = K_PLUS;
      8'h3B:   single_kind = K_SEMI;
      8'h2A:   single_kind = K_STAR;
      default: single_kind = K_ERROR;
    endcase
  endfunction

  // prefix holds up to six characters, first in the low byte, zero padded
  function automatic logic [5:0] kw_kind(input logic [47:0] p, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case ({n, p})
      {3'd3, 48'h000000646e61}: k = 6'd23;
      {3'd5, 48'h00737361_6c63}: k = 6'd24;
      {3'd5, 48'h0074736e_6f63}: k = 6'd25;
      {3'd4, 48'h0000_65736c65}: k = 6'd26;
      {3'd5, 48'h0065736c_6166}: k = 6'd27;
      {3'd3, 48'h000000726f66}: k = 6'd28;
      {3'd3, 48'h0000006e7566}: k = 6'd29;
      {3'd2, 48'h000000006669}: k = 6'd30;
      {3'd3, 48'h00000074656c}: k = 6'd31;
      {3'd4, 48'h00006c6c756e}: k = 6'd32;
      {3'd2, 48'h00000000726f}: k = 6'd33;
      {3'd5, 48'h00746e69_7270}: k = 6'd34;
      {3'd6, 48'h6e7275746572}: k = 6'd35;
      {3'd5, 48'h00726570_7573}: k = 6'd36;
      {3'd4, 48'h000073696874}: k = 6'd37;
      {3'd4, 48'h000065757274}: k = 6'd38;
      {3'd3, 48'h000000726176}: k = 6'd39;
      {3'd5, 48'h00656c69_6877}: k = 6'd40;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### design/ssl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssl_front
// Accepts source bytes, classifies them and queues them for the scanner.
// ---------------------------------------------------------------------------
module ssl_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire       [7:0] in_byte,
  input  wire             in_eoi,
  output logic            q_valid,
  input  wire             q_ready,
  output ssl_pkg::cls_t   q_data
);
  import ssl_pkg::*;

  cls_t       slot [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       push, pop;
  cls_t       cls;

  always_comb begin
    cls.ch    = in_byte;
    cls.eoi   = in_eoi || (in_byte == 8'h00);
    cls.digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    cls.alnum = cls.digit || ((in_byte >= 8'h61) && (in_byte <= 8'h7A))
                || ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) || (in_byte == 8'h5F);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### design/ssl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssl_back
// Scanner state machine; turns one classified byte into up to three tokens
// and serialises them out through a token register.
// ---------------------------------------------------------------------------
module ssl_back #(
  parameter int OFFSET_BITS   = ssl_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS   = ssl_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS     = ssl_pkg::LINE_BITS_DEF,
  parameter int KEYWORD_CHARS = ssl_pkg::KEYWORD_CHARS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    q_valid,
  output logic                   q_ready,
  input  ssl_pkg::cls_t          q_data,
  output logic                   tok_valid,
  input  wire                    tok_ready,
  output logic [5:0]             tok_kind,
  output logic [1:0]             tok_err,
  output logic [OFFSET_BITS-1:0] tok_off,
  output logic [LENGTH_BITS-1:0] tok_len,
  output logic [LINE_BITS-1:0]   tok_line,
  output logic                   tok_last
);
  import ssl_pkg::*;

  localparam int PB = 8 * KEYWORD_CHARS;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  typedef struct packed {
    logic [5:0]             kind;
    logic [1:0]             err;
    logic [OFFSET_BITS-1:0] off;
    logic [LENGTH_BITS-1:0] len;
  } tok_t;

  // scanner state
  logic [2:0]             mode;
  logic [7:0]             pend;
  logic [OFFSET_BITS-1:0] start;
  logic [LENGTH_BITS-1:0] run;
  logic [LINE_BITS-1:0]   line;
  logic [OFFSET_BITS-1:0] pos;
  logic [PB-1:0]          prefix;
  logic                   frac;

  logic [2:0]             mode_next;
  logic [7:0]             pend_next;
  logic [OFFSET_BITS-1:0] start_next;
  logic [LENGTH_BITS-1:0] run_next;
  logic [LINE_BITS-1:0]   line_next;
  logic [PB-1:0]          prefix_next;
  logic                   frac_next;

  // output holding: up to three tokens
  tok_t             hold [3];
  logic [LINE_BITS-1:0] hold_line;
  logic [1:0]       hold_n, hold_i;
  tok_t             gen [3];
  logic [1:0]       gen_n;

  logic [7:0]             c;
  logic                   eoi, consumed, take;
  logic [LENGTH_BITS-1:0] run_inc, run_inc2;
  logic [5:0]             idk;
  logic [LINE_BITS-1:0]   line_inc;

  assign c        = q_data.ch;
  assign eoi      = q_data.eoi;
  assign run_inc  = (run == LEN_MAX) ? run : run + 1'b1;
  assign run_inc2 = (run_inc == LEN_MAX) ? run_inc : run_inc + 1'b1;
  assign line_inc = (line == LINE_MAX) ? line : line + 1'b1;
  assign idk      = (run > LENGTH_BITS'(KEYWORD_CHARS)) ? K_IDENT
                    : kw_kind(48'(prefix[PB-1:0]), 3'(run));

  // accept when the holding stage is empty or drains its final token
  assign q_ready = (hold_n == 2'd0) || (tok_ready && (hold_i == hold_n - 2'd1));
  assign take    = q_valid && q_ready;

  always_comb begin
    tok_t t;
    t = '{kind: K_EOF, err: ERR_NONE, off: '0, len: '0};
    for (int i = 0; i < 3; i++) gen[i] = t;
    gen_n       = 2'd0;
    mode_next   = mode;
    pend_next   = pend;
    start_next  = start;
    run_next    = run;
    line_next   = line;
    prefix_next = prefix;
    frac_next   = frac;
    consumed    = 1'b0;

    case (mode)
      M_OP2: begin
        if (!eoi && pend == 8'h2F && c == 8'h2F) begin
          mode_next = M_COMMENT;
          pend_next = 8'h00;
          consumed  = 1'b1;
        end else if (!eoi && pend != 8'h2F && c == 8'h3D) begin
          gen[0] = '{kind: op_base(pend) + 6'd1, err: ERR_NONE, off: start,
                     len: LENGTH_BITS'(2)};
          gen_n = 2'd1;
          consumed = 1'b1;
        end else begin
          gen[0] = '{kind: op_base(pend), err: ERR_NONE, off: start,
                     len: LENGTH_BITS'(1)};
          gen_n = 2'd1;
        end
      end
      M_COMMENT: begin
        if (eoi) consumed = 1'b0;
        else begin
          consumed = 1'b1;
          if (c == 8'h0A) line_next = line_inc;
        end
      end
      M_NUMBER: begin
        if (!eoi && q_data.digit) begin
          run_next = run_inc;
          consumed = 1'b1;
        end else if (!eoi && !frac && c == 8'h2E) begin
          mode_next = M_NUMDOT;
          consumed = 1'b1;
        end else if (!eoi && !frac && c == 8'h6E) begin
          gen[0] = '{kind: K_BIGINT, err: ERR_NONE, off: start, len: run_inc};
          gen_n = 2'd1;
          consumed = 1'b1;
        end else begin
          gen[0] = '{kind: K_NUMBER, err: ERR_NONE, off: start, len: run};
          gen_n = 2'd1;
        end
      end
      M_NUMDOT: begin
        if (!eoi && q_data.digit) begin
          run_next  = run_inc2;
          frac_next = 1'b1;
          mode_next = M_NUMBER;
          consumed  = 1'b1;
        end else begin
          gen[0] = '{kind: K_NUMBER, err: ERR_NONE, off: start, len: run};
          gen[1] = '{kind: K_DOT, err: ERR_NONE, off: pos - 1'b1,
                     len: LENGTH_BITS'(1)};
          gen_n = 2'd2;
        end
      end
      M_IDENT: begin
        if (!eoi && q_data.alnum) begin
          for (int j = 0; j < KEYWORD_CHARS; j++) begin
            if (run == LENGTH_BITS'(j)) prefix_next[8*j +: 8] = c;
          end
          run_next = run_inc;
          consumed = 1'b1;
        end else begin
          gen[0] = '{kind: idk, err: ERR_NONE, off: start, len: run};
          gen_n = 2'd1;
        end
      end
      M_STRING: begin
        if (eoi) begin
          gen[0] = '{kind: K_ERROR, err: ERR_UNTERM, off: start, len: run};
          gen_n = 2'd1;
        end else begin
          consumed = 1'b1;
          run_next = run_inc;
          if (c == 8'h22) begin
            gen[0] = '{kind: K_STRING, err: ERR_NONE, off: start, len: run_inc};
            gen_n = 2'd1;
          end else if (c == 8'h0A) begin
            line_next = line_inc;
          end
        end
      end
      default: consumed = 1'b0;
    endcase

    // idle return for every case that ended or handed back the byte
    if (!consumed || (mode == M_OP2 && mode_next != M_COMMENT)
        || (mode == M_COMMENT && c == 8'h0A)
        || (mode == M_NUMBER && gen_n != 2'd0)
        || (mode == M_STRING && gen_n != 2'd0)) begin
      if (!(mode == M_OP2 && mode_next == M_COMMENT)) begin
        mode_next = M_IDLE; pend_next = 8'h00; run_next = '0;
        prefix_next = '0; frac_next = 1'b0;
        if (consumed && mode == M_STRING) run_next = '0;
      end
    end

    if (!consumed) begin
      if (eoi) begin
        gen[gen_n] = '{kind: K_EOF, err: ERR_NONE, off: pos, len: '0};
        gen_n = gen_n + 2'd1;
      end else begin
        case (c)
          8'h20, 8'h0D, 8'h09: ;
          8'h0A: line_next = line_inc;
          8'h2F, 8'h21, 8'h3D, 8'h3C, 8'h3E: begin
            mode_next = M_OP2; pend_next = c; start_next = pos;
          end
          8'h22: begin
            mode_next = M_STRING; start_next = pos; run_next = LENGTH_BITS'(1);
          end
          default: begin
            if (single_kind(c) != K_ERROR) begin
              gen[gen_n] = '{kind: single_kind(c), err: ERR_NONE, off: pos,
                             len: LENGTH_BITS'(1)};
              gen_n = gen_n + 2'd1;
            end else if (q_data.digit) begin
              mode_next = M_NUMBER; frac_next = 1'b0; start_next = pos;
              run_next = LENGTH_BITS'(1);
            end else if (q_data.alnum) begin
              mode_next = M_IDENT; start_next = pos; run_next = LENGTH_BITS'(1);
              prefix_next = PB'(c);
            end else begin
              gen[gen_n] = '{kind: K_ERROR, err: ERR_UNEXPECT, off: pos,
                             len: LENGTH_BITS'(1)};
              gen_n = gen_n + 2'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pend <= 8'h00; start <= '0; run <= '0;
      line <= LINE_BITS'(1); pos <= '0; prefix <= '0; frac <= 1'b0;
    end else if (take) begin
      mode <= mode_next; pend <= pend_next; start <= start_next;
      run <= run_next; line <= line_next; prefix <= prefix_next;
      frac <= frac_next;
      if (!eoi) pos <= pos + 1'b1;
    end
  end

  // token register: tokens of one byte all carry the line count from before it
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) hold[i] <= gen[i];
      hold_line <= line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_n <= 2'd0; hold_i <= 2'd0;
    end else if (take) begin
      hold_n <= gen_n; hold_i <= 2'd0;
    end else if (tok_valid && tok_ready) begin
      if (hold_i == hold_n - 2'd1) hold_n <= 2'd0;
      else hold_i <= hold_i + 2'd1;
    end
  end

  assign tok_valid = (hold_n != 2'd0);
  assign tok_kind  = hold[hold_i].kind;
  assign tok_err   = hold[hold_i].err;
  assign tok_off   = hold[hold_i].off;
  assign tok_len   = hold[hold_i].len;
  assign tok_line  = hold_line;
  assign tok_last  = (hold_i == hold_n - 2'd1);

endmodule
`default_nettype wire

### design/script_source_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// script_source_lexer
// Streaming lexer: source bytes in, tokens out.
// ---------------------------------------------------------------------------
// One source byte is taken per clock while fewer than two tokens are due for
// it and the output accepts; a byte with more tokens holds the scanner while
// the token register hands them out one per cycle as the output accepts. A
// two-entry byte queue between the input classifier and the scanner lets
// input keep flowing while the output side stalls, until the queue is full.
module script_source_lexer #(
  parameter int OFFSET_BITS   = ssl_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS   = ssl_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS     = ssl_pkg::LINE_BITS_DEF,
  parameter int KEYWORD_CHARS = ssl_pkg::KEYWORD_CHARS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,  // src_byte
  input  wire         s_axis_tlast,  // end_of_input
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [OFFSET_BITS+LENGTH_BITS+LINE_BITS+7:0] m_axis_tdata,
  // token_kind[5:0], error_kind, token_offset, token_length, line_number
  output logic        m_axis_tlast   // last_of_run
);
  import ssl_pkg::*;

  logic                   q_valid, q_ready;
  cls_t                   q_data;
  logic [5:0]             kind;
  logic [1:0]             err;
  logic [OFFSET_BITS-1:0] off;
  logic [LENGTH_BITS-1:0] len;
  logic [LINE_BITS-1:0]   ln;

  ssl_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_eoi(s_axis_tlast),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  ssl_back #(
    .OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS),
    .LINE_BITS(LINE_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .tok_valid(m_axis_tvalid), .tok_ready(m_axis_tready),
    .tok_kind(kind), .tok_err(err), .tok_off(off), .tok_len(len),
    .tok_line(ln), .tok_last(m_axis_tlast)
  );

  assign m_axis_tdata = {ln, len, off, err, kind};

endmodule
`default_nettype wire

### design/ssl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssl_checker
// Port-level checks on the lexer's token output stream.
// ---------------------------------------------------------------------------
module ssl_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [79:0] m_axis_tdata,
  input wire        m_axis_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("token changed under stall");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[5:0] <= 6'd42)
    else $error("token kind out of range");
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5:0] != 6'd41 |-> m_axis_tdata[7:6] == 2'd0)
    else $error("error kind on non-error token");
  a_line: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[79:56] != 24'd0)
    else $error("line number zero");
  a_eof: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5:0] == 6'd42 |-> m_axis_tlast)
    else $error("eof not last of run");
endmodule

bind script_source_lexer ssl_checker u_chk (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
